// ===== rtl/core/atomic_temperature_factor_macros.svh =====
// Assertion macros of the temperature factor RTL.
`ifndef ATOMIC_TEMPERATURE_FACTOR_MACROS_SVH
`define ATOMIC_TEMPERATURE_FACTOR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define ATF_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("temperature factor check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define ATF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("temperature factor check failed");
`else
`define ATF_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ATF_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/atf_pkg.sv =====
// Shared types, constants and divider helpers of the temperature factor block.
`timescale 1ns / 1ps
`default_nettype none
package atf_pkg;
   // Register indexes on the configuration port.
   localparam logic [2:0] REG_MODE = 3'd0;
   localparam logic [2:0] REG_B_ISO = 3'd1;
   localparam logic [2:0] REG_BETA_11 = 3'd2;
   localparam logic [2:0] REG_BETA_22 = 3'd3;
   localparam logic [2:0] REG_BETA_33 = 3'd4;
   localparam logic [2:0] REG_BETA_12 = 3'd5;
   localparam logic [2:0] REG_BETA_13 = 3'd6;
   localparam logic [2:0] REG_BETA_23 = 3'd7;

   // Fixed-point constants of the exponential, 30 fraction bits.
   localparam logic [29:0] LN2_Q30 = 30'd744261118;
   localparam logic signed [52:0] LN4_NEG = -53'sd1488522236;
   // Exponents above 25*ln2 underflow the output to zero.
   localparam logic [34:0] ZERO_LIMIT = 35'd18606527950;
   // floor(2^16 / ln2) for the quotient estimate.
   localparam logic [16:0] LN2_RECIP = 17'd94548;
   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
   // Right shift minus one for a quotient of zero (14 + 25 - 1).
   localparam logic [5:0] ROUND_BASE = 6'd38;
   localparam int unsigned POLY_TERMS = 10;
   localparam logic [17:0] OUT_MAX = 18'h3FFFF;

   // Control bits that travel with each transaction.
   typedef struct packed {
      logic valid;
      logic sat;
      logic zero;
   } ctl_type;

   // One result transaction.
   typedef struct packed {
      logic [17:0] temp_factor;
      logic saturated;
   } res_type;

   // Multiplier m = ceil(2^(31+l)/k), with l = ceil(log2 k), for an exact
   // floor division of a 31-bit value by k.
   function automatic logic [31:0] recip_mul(input int unsigned k);
      logic [31:0] m;
      case (k)
         10: m = 32'd3435973837;
         9: m = 32'd3817748708;
         7: m = 32'd2454267027;
         6: m = 32'd2863311531;
         5: m = 32'd3435973837;
         3: m = 32'd2863311531;
         default: m = 32'h8000_0000;
      endcase
      return m;
   endfunction

   // Matching right shift 31 + ceil(log2 k).
   function automatic logic [5:0] recip_shift(input int unsigned k);
      logic [5:0] s;
      case (k)
         10, 9: s = 6'd35;
         8, 7, 6, 5: s = 6'd34;
         4, 3: s = 6'd33;
         2: s = 6'd32;
         default: s = 6'd31;
      endcase
      return s;
   endfunction
endpackage
`default_nettype wire

// ===== rtl/core/atf_req_if.sv =====
// Reflection request channel: valid/ready handshake with the input fields.
`timescale 1ns / 1ps
`default_nettype none
interface atf_req_if;
   logic valid;
   logic ready;
   logic [17:0] sin_theta_over_lambda;
   logic signed [7:0] miller_h;
   logic signed [7:0] miller_k;
   logic signed [7:0] miller_l;

   modport source (output valid, sin_theta_over_lambda, miller_h, miller_k, miller_l,
                   input ready);
   modport sink (input valid, sin_theta_over_lambda, miller_h, miller_k, miller_l,
                 output ready);
endinterface
`default_nettype wire

// ===== rtl/core/atf_rsp_if.sv =====
// Result channel: valid/ready handshake with the temperature factor fields.
`timescale 1ns / 1ps
`default_nettype none
interface atf_rsp_if;
   logic valid;
   logic ready;
   logic [17:0] temp_factor;
   logic saturated;

   modport source (output valid, temp_factor, saturated, input ready);
   modport sink (input valid, temp_factor, saturated, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/atf_exp.sv =====
// Pipelined exp(-x): range reduction by ln2, ten-term Horner series, rounding.
`timescale 1ns / 1ps
`default_nettype none
module atf_exp (
   input wire logic clock,
   input wire logic reset,
   input wire logic adv,
   input wire atf_pkg::ctl_type in_ctl,
   input wire logic [34:0] in_u,
   output atf_pkg::ctl_type out_ctl,
   output atf_pkg::res_type out_res
);
   localparam int unsigned NT = atf_pkg::POLY_TERMS;

   // Stage E1: quotient estimate of u / ln2, low by at most one.
   atf_pkg::ctl_type e1_ctl_ff;
   logic [34:0] e1_u_ff;
   logic [4:0] e1_qe_ff;
   logic [35:0] e1_mul_in;
   assign e1_mul_in = 36'(in_u[34:16]) * 36'(atf_pkg::LN2_RECIP);

   // Stage E2: remainder against the estimate.
   atf_pkg::ctl_type e2_ctl_ff;
   logic [30:0] e2_r0_ff;
   logic [4:0] e2_q_ff;
   logic [34:0] e2_r0_in;
   assign e2_r0_in = e1_u_ff - 35'(e1_qe_ff) * 35'(atf_pkg::LN2_Q30);

   // Stage E3: one correction step brings the remainder under ln2.
   atf_pkg::ctl_type e3_ctl_ff;
   logic [29:0] e3_r_ff;
   logic [4:0] e3_q_ff;
   logic e3_fix_in;
   assign e3_fix_in = (e2_r0_ff >= 31'(atf_pkg::LN2_Q30));

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_ctl_ff <= '0;
         e2_ctl_ff <= '0;
         e3_ctl_ff <= '0;
      end else if (adv) begin
         e1_ctl_ff <= in_ctl;
         e2_ctl_ff <= e1_ctl_ff;
         e3_ctl_ff <= e2_ctl_ff;
      end
      if (adv) begin
         e1_u_ff <= in_u;
         e1_qe_ff <= e1_mul_in[34:30];
         e2_r0_ff <= e2_r0_in[30:0];
         e2_q_ff <= e1_qe_ff;
         e3_r_ff <= e3_fix_in ? 30'(e2_r0_ff - 31'(atf_pkg::LN2_Q30)) : e2_r0_ff[29:0];
         e3_q_ff <= e3_fix_in ? e2_q_ff + 5'd1 : e2_q_ff;
      end
   end

   // Horner series: per term a multiply by r, then an exact divide by k.
   atf_pkg::ctl_type ha_ctl_ff [NT];
   atf_pkg::ctl_type hb_ctl_ff [NT];
   logic [29:0] ha_r_ff [NT];
   logic [29:0] hb_r_ff [NT];
   logic [4:0] ha_q_ff [NT];
   logic [4:0] hb_q_ff [NT];
   logic [30:0] ha_p_ff [NT];
   logic [30:0] hb_d_ff [NT];
   logic [30:0] ha_p_in [NT];
   logic [30:0] hb_d_in [NT];

   for (genvar j = 0; j < NT; j++) begin : g_term
      localparam int unsigned K = NT - j;
      localparam logic [31:0] MK = atf_pkg::recip_mul(K);
      localparam logic [5:0] SK = atf_pkg::recip_shift(K);
      atf_pkg::ctl_type src_ctl;
      logic [29:0] src_r;
      logic [4:0] src_q;
      logic [30:0] src_acc;
      logic [60:0] a_mul;
      logic [62:0] b_mul;

      if (j == 0) begin : g_first
         assign src_ctl = e3_ctl_ff;
         assign src_r = e3_r_ff;
         assign src_q = e3_q_ff;
         assign src_acc = atf_pkg::ONE_Q30;
      end else begin : g_next
         assign src_ctl = hb_ctl_ff[j-1];
         assign src_r = hb_r_ff[j-1];
         assign src_q = hb_q_ff[j-1];
         assign src_acc = atf_pkg::ONE_Q30 + hb_d_ff[j-1];
      end

      assign a_mul = 61'(src_acc) * 61'(src_r);
      assign ha_p_in[j] = a_mul[60:30];
      assign b_mul = 63'(ha_p_ff[j]) * 63'(MK);
      assign hb_d_in[j] = 31'(b_mul >> SK);

      always_ff @(posedge clock) begin
         if (reset) begin
            ha_ctl_ff[j] <= '0;
            hb_ctl_ff[j] <= '0;
         end else if (adv) begin
            ha_ctl_ff[j] <= src_ctl;
            hb_ctl_ff[j] <= ha_ctl_ff[j];
         end
         if (adv) begin
            ha_r_ff[j] <= src_r;
            ha_q_ff[j] <= src_q;
            ha_p_ff[j] <= ha_p_in[j];
            hb_r_ff[j] <= ha_r_ff[j];
            hb_q_ff[j] <= ha_q_ff[j];
            hb_d_ff[j] <= hb_d_in[j];
         end
      end
   end

   // Final stage: scale by 2^n with round half up, then force to zero or clamp.
   logic [30:0] fin_acc_in;
   logic [5:0] fin_sh_in;
   logic [18:0] fin_rnd_in;
   logic [18:0] fin_res_in;
   atf_pkg::res_type fin_out_in;
   atf_pkg::ctl_type fin_ctl_ff;
   atf_pkg::res_type fin_res_ff;

   always_comb begin
      fin_acc_in = atf_pkg::ONE_Q30 + hb_d_ff[NT-1];
      fin_sh_in = atf_pkg::ROUND_BASE - 6'(hb_q_ff[NT-1]);
      fin_rnd_in = 19'(fin_acc_in >> fin_sh_in);
      fin_res_in = 19'((20'(fin_rnd_in) + 20'd1) >> 1);
      if (hb_ctl_ff[NT-1].zero) begin
         fin_out_in = '{temp_factor: 18'd0, saturated: 1'b0};
      end else if (hb_ctl_ff[NT-1].sat || fin_res_in[18]) begin
         fin_out_in = '{temp_factor: atf_pkg::OUT_MAX, saturated: 1'b1};
      end else begin
         fin_out_in = '{temp_factor: fin_res_in[17:0], saturated: 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ctl_ff <= '0;
      end else if (adv) begin
         fin_ctl_ff <= hb_ctl_ff[NT-1];
      end
      if (adv) begin
         fin_res_ff <= fin_out_in;
      end
   end

   assign out_ctl = fin_ctl_ff;
   assign out_res = fin_res_ff;
endmodule
`default_nettype wire

// ===== rtl/core/atomic_temperature_factor.sv =====
// Top level of the Debye-Waller temperature factor pipeline with its registers.
`timescale 1ns / 1ps
`default_nettype none
`include "atomic_temperature_factor_macros.svh"
// Computes exp(-B*s^2) (isotropic) or exp(-sum of beta terms over h,k,l)
// (anisotropic) for one reflection per transaction, result in Q2.16 with a
// saturation flag. One transaction is taken every cycle while the result queue
// is not full; a result is presented on the rsp channel from the result queue.
// Most of the pipeline stages lie in the exponential: a three-stage reduction
// by ln2 followed by a ten-term Horner series, each term one multiplier stage
// and one reciprocal-divide stage. A two-entry result queue decouples
// rsp_chan.ready from the pipeline; the pipeline freezes only while that queue
// is full. Registers are written through the APB port and should be changed
// only while no transaction is in flight.
module atomic_temperature_factor (
   input wire logic clock,
   input wire logic reset,
   atf_req_if.sink req_chan,
   atf_rsp_if.source rsp_chan,
   input wire logic psel,
   input wire logic penable,
   input wire logic pwrite,
   input wire logic [4:0] paddr,
   input wire logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   // Configuration registers.
   logic mode_ff;
   logic [23:0] b_iso_ff;
   logic signed [31:0] beta_ff [6];
   logic csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b1;
         b_iso_ff <= 24'd65536;
         for (int i = 0; i < 6; i++) begin
            beta_ff[i] <= '0;
         end
      end else if (csr_wr) begin
         case (paddr[4:2])
            atf_pkg::REG_MODE: mode_ff <= pwdata[0];
            atf_pkg::REG_B_ISO: b_iso_ff <= pwdata[23:0];
            atf_pkg::REG_BETA_11: beta_ff[0] <= pwdata;
            atf_pkg::REG_BETA_22: beta_ff[1] <= pwdata;
            atf_pkg::REG_BETA_33: beta_ff[2] <= pwdata;
            atf_pkg::REG_BETA_12: beta_ff[3] <= pwdata;
            atf_pkg::REG_BETA_13: beta_ff[4] <= pwdata;
            atf_pkg::REG_BETA_23: beta_ff[5] <= pwdata;
            default: mode_ff <= mode_ff;
         endcase
      end
   end

   // Register readback.
   always_comb begin
      case (paddr[4:2])
         atf_pkg::REG_MODE: prdata = {31'd0, mode_ff};
         atf_pkg::REG_B_ISO: prdata = {8'd0, b_iso_ff};
         atf_pkg::REG_BETA_11: prdata = beta_ff[0];
         atf_pkg::REG_BETA_22: prdata = beta_ff[1];
         atf_pkg::REG_BETA_33: prdata = beta_ff[2];
         atf_pkg::REG_BETA_12: prdata = beta_ff[3];
         atf_pkg::REG_BETA_13: prdata = beta_ff[4];
         atf_pkg::REG_BETA_23: prdata = beta_ff[5];
         default: prdata = '0;
      endcase
   end

   // The whole pipeline advances together unless the result queue is full.
   logic adv;
   logic [1:0] q_count_ff;
   assign adv = (q_count_ff != 2'd2);
   assign req_chan.ready = adv;

   // Stage 1: capture the request.
   logic s1_valid_ff;
   logic [17:0] s1_s_ff;
   logic signed [7:0] s1_h_ff, s1_k_ff, s1_l_ff;

   // Stage 2: s^2 and the six index products (hh, kk, ll, hk, hl, kl).
   logic s2_valid_ff;
   logic [35:0] s2_ss_ff, s2_ss_in;
   logic signed [15:0] s2_pq_ff [6];
   logic signed [15:0] s2_pq_in [6];

   always_comb begin
      s2_ss_in = 36'(s1_s_ff) * 36'(s1_s_ff);
      s2_pq_in[0] = 16'(s1_h_ff) * 16'(s1_h_ff);
      s2_pq_in[1] = 16'(s1_k_ff) * 16'(s1_k_ff);
      s2_pq_in[2] = 16'(s1_l_ff) * 16'(s1_l_ff);
      s2_pq_in[3] = 16'(s1_h_ff) * 16'(s1_k_ff);
      s2_pq_in[4] = 16'(s1_h_ff) * 16'(s1_l_ff);
      s2_pq_in[5] = 16'(s1_k_ff) * 16'(s1_l_ff);
   end

   // Stage 3: B*s^2 scaled to 30 fraction bits, and each beta times its product.
   logic s3_valid_ff;
   logic [41:0] s3_eiso_ff, s3_eiso_in;
   logic signed [47:0] s3_p_ff [6];
   logic signed [47:0] s3_p_in [6];

   always_comb begin
      s3_eiso_in = 42'((60'(b_iso_ff) * 60'(s2_ss_ff)) >> 18);
      for (int i = 0; i < 6; i++) begin
         s3_p_in[i] = 48'(beta_ff[i]) * 48'(s2_pq_ff[i]);
      end
   end

   // Stage 4: partial sums of the square terms and of the cross terms.
   logic s4_valid_ff;
   logic [41:0] s4_eiso_ff;
   logic signed [49:0] s4_a_ff, s4_a_in, s4_b_ff, s4_b_in;
   assign s4_a_in = 50'(s3_p_ff[0]) + 50'(s3_p_ff[1]) + 50'(s3_p_ff[2]);
   assign s4_b_in = 50'(s3_p_ff[3]) + 50'(s3_p_ff[4]) + 50'(s3_p_ff[5]);

   // Stage 5: exponent, B*s^2 in isotropic mode; in anisotropic mode the cross terms count twice.
   logic s5_valid_ff;
   logic signed [52:0] s5_e_ff, s5_e_in;
   assign s5_e_in = mode_ff ? $signed({11'd0, s4_eiso_ff})
                            : 53'(s4_a_ff) + (53'(s4_b_ff) <<< 1);

   // Stage 6: saturation and underflow decisions, offset argument for the divide.
   atf_pkg::ctl_type s6_ctl_ff, s6_ctl_in;
   logic [34:0] s6_u_ff, s6_u_in;
   always_comb begin
      s6_ctl_in.valid = s5_valid_ff;
      s6_ctl_in.sat = (s5_e_ff <= atf_pkg::LN4_NEG);
      s6_ctl_in.zero = (s5_e_ff > $signed({18'd0, atf_pkg::ZERO_LIMIT}));
      s6_u_in = atf_pkg::ZERO_LIMIT - s5_e_ff[34:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_ctl_ff <= '0;
      end else if (adv) begin
         s1_valid_ff <= req_chan.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_ctl_ff <= s6_ctl_in;
      end
      if (adv) begin
         s1_s_ff <= req_chan.sin_theta_over_lambda;
         s1_h_ff <= req_chan.miller_h;
         s1_k_ff <= req_chan.miller_k;
         s1_l_ff <= req_chan.miller_l;
         s2_ss_ff <= s2_ss_in;
         s2_pq_ff <= s2_pq_in;
         s3_eiso_ff <= s3_eiso_in;
         s3_p_ff <= s3_p_in;
         s4_eiso_ff <= s3_eiso_ff;
         s4_a_ff <= s4_a_in;
         s4_b_ff <= s4_b_in;
         s5_e_ff <= s5_e_in;
         s6_u_ff <= s6_u_in;
      end
   end

   // Exponential pipeline.
   atf_pkg::ctl_type fin_ctl;
   atf_pkg::res_type fin_res;

   atf_exp u_exp (
      .clock (clock),
      .reset (reset),
      .adv (adv),
      .in_ctl (s6_ctl_ff),
      .in_u (s6_u_ff),
      .out_ctl (fin_ctl),
      .out_res (fin_res)
   );

   // Two-entry result queue.
   atf_pkg::res_type q_mem_ff [2];
   logic q_wr_ff, q_rd_ff;
   logic q_push, q_pop;
   assign q_push = adv & fin_ctl.valid;
   assign q_pop = rsp_chan.valid & rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff <= 1'b0;
         q_rd_ff <= 1'b0;
         q_count_ff <= 2'd0;
      end else begin
         if (q_push) begin
            q_wr_ff <= ~q_wr_ff;
         end
         if (q_pop) begin
            q_rd_ff <= ~q_rd_ff;
         end
         q_count_ff <= q_count_ff + 2'(q_push) - 2'(q_pop);
      end
      if (q_push) begin
         q_mem_ff[q_wr_ff] <= fin_res;
      end
   end

   assign rsp_chan.valid = (q_count_ff != 2'd0);
   assign rsp_chan.temp_factor = q_mem_ff[q_rd_ff].temp_factor;
   assign rsp_chan.saturated = q_mem_ff[q_rd_ff].saturated;

   // Checks on the pipeline and the result queue.
   `ATF_ASSERT_IMPLY(a_q_bound, clock, reset, 1'b1, q_count_ff != 2'd3)
   `ATF_ASSERT_NEXT(a_q_fill, clock, reset, q_push && !q_pop, q_count_ff == $past(q_count_ff) + 2'd1)
   `ATF_ASSERT_IMPLY(a_flags_excl, clock, reset, s6_ctl_ff.valid, !(s6_ctl_ff.sat && s6_ctl_ff.zero))
   `ATF_ASSERT_IMPLY(a_sat_max, clock, reset, rsp_chan.valid && rsp_chan.saturated, rsp_chan.temp_factor == atf_pkg::OUT_MAX)
endmodule
`default_nettype wire
